// ===== sv/sblt_pkg.sv =====
// shared types, codes and controller state encoding for the size budget lru tracker
package sblt_pkg;

    // request kinds
    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_HIT = 2'd1;
    localparam logic [1:0] MODE_DEL = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_EVICT  = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;

    localparam logic [31:0] BUDGET_RESET = 32'd1048576;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] key;
        logic [23:0] entry_size;
    } req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] out_key;
        logic        found;
        logic [31:0] total_bytes;
        logic        last;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ADD_EVICT,
        ST_ADD_FULL,
        ST_ADD_DONE,
        ST_SCAN_HIT,
        ST_SCAN_DEL,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic       load;
        logic       idx_inc;
        logic       add_total;
        logic       drop;
        logic       move;
        logic       at_idx;
        logic       sub_total;
        logic       append;
        logic       set_found;
        logic       emit;
        logic [1:0] kind;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] mode;
        logic       out_free;
        logic       over;
        logic       empty;
        logic       full;
        logic       idx_end;
        logic       match;
    } stat_t;

endpackage

// ===== sv/sblt_ctrl.sv =====
// sequencing state machine for the size budget lru tracker
module sblt_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  sblt_pkg::stat_t  stat,
    output sblt_pkg::cmd_t   cmd,
    output logic             busy
);

    sblt_pkg::state_t state_reg;
    sblt_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sblt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = (state_reg != sblt_pkg::ST_IDLE);
        unique case (state_reg)
            sblt_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sblt_pkg::ST_DECODE;
                end
            end
            sblt_pkg::ST_DECODE:
            begin
                priority if (stat.mode == sblt_pkg::MODE_ADD)
                begin
                    cmd.add_total = 1'b1;
                    state_next    = sblt_pkg::ST_ADD_EVICT;
                end
                else if (stat.mode == sblt_pkg::MODE_HIT)
                begin
                    state_next = sblt_pkg::ST_SCAN_HIT;
                end
                else if (stat.mode == sblt_pkg::MODE_DEL)
                begin
                    state_next = sblt_pkg::ST_SCAN_DEL;
                end
                else
                begin
                    state_next = sblt_pkg::ST_DONE;
                end
            end
            sblt_pkg::ST_ADD_EVICT:
            begin
                if (stat.over && !stat.empty)
                begin
                    if (stat.out_free)
                    begin
                        cmd.drop      = 1'b1;
                        cmd.sub_total = 1'b1;
                        cmd.emit      = 1'b1;
                        cmd.kind      = sblt_pkg::KIND_EVICT;
                    end
                end
                else
                begin
                    state_next = sblt_pkg::ST_ADD_FULL;
                end
            end
            sblt_pkg::ST_ADD_FULL:
            begin
                if (stat.full)
                begin
                    if (stat.out_free)
                    begin
                        cmd.drop      = 1'b1;
                        cmd.sub_total = 1'b1;
                        cmd.emit      = 1'b1;
                        cmd.kind      = sblt_pkg::KIND_EVICT;
                        state_next    = sblt_pkg::ST_ADD_DONE;
                    end
                end
                else
                begin
                    state_next = sblt_pkg::ST_ADD_DONE;
                end
            end
            sblt_pkg::ST_ADD_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.append = 1'b1;
                    cmd.emit   = 1'b1;
                    cmd.kind   = sblt_pkg::KIND_DONE;
                    state_next = sblt_pkg::ST_IDLE;
                end
            end
            sblt_pkg::ST_SCAN_HIT:
            begin
                priority if (stat.idx_end)
                begin
                    state_next = sblt_pkg::ST_DONE;
                end
                else if (stat.match)
                begin
                    cmd.move      = 1'b1;
                    cmd.at_idx    = 1'b1;
                    cmd.set_found = 1'b1;
                    state_next    = sblt_pkg::ST_DONE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            sblt_pkg::ST_SCAN_DEL:
            begin
                priority if (stat.idx_end)
                begin
                    state_next = sblt_pkg::ST_DONE;
                end
                else if (stat.match)
                begin
                    if (stat.out_free)
                    begin
                        cmd.drop      = 1'b1;
                        cmd.at_idx    = 1'b1;
                        cmd.sub_total = 1'b1;
                        cmd.set_found = 1'b1;
                        cmd.emit      = 1'b1;
                        cmd.kind      = sblt_pkg::KIND_REMOVE;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            sblt_pkg::ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = sblt_pkg::KIND_DONE;
                    state_next = sblt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sblt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/sblt_datapath.sv =====
// recency list, running total, budget register and result register
module sblt_datapath
#(
    parameter int MAX_ENTRIES = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  sblt_pkg::req_t   req,
    input  logic             cfg_wr_en,
    input  logic [31:0]      cfg_wr_data,
    input  sblt_pkg::cmd_t   cmd,
    output sblt_pkg::stat_t  stat,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output sblt_pkg::rsp_t   rsp
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int IW = $clog2(MAX_ENTRIES);

    logic [15:0]    keys_reg  [MAX_ENTRIES];
    logic [15:0]    keys_next [MAX_ENTRIES];
    logic [23:0]    sizes_reg  [MAX_ENTRIES];
    logic [23:0]    sizes_next [MAX_ENTRIES];
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic [CW-1:0]  idx_reg;
    logic [CW-1:0]  idx_next;
    logic [31:0]    total_reg;
    logic [31:0]    total_next;
    logic [31:0]    budget_reg;
    sblt_pkg::req_t req_reg;
    logic           found_reg;
    logic           rsp_valid_reg;
    sblt_pkg::rsp_t rsp_reg;

    logic [IW-1:0]  pos;
    logic [IW-1:0]  wpos;
    logic [15:0]    wkey;
    logic [23:0]    wsize;
    logic           wr;
    logic [23:0]    pos_size;
    logic [15:0]    rd_key;
    logic [32:0]    sum;

    assign pos      = cmd.at_idx ? idx_reg[IW-1:0] : '0;
    assign pos_size = sizes_reg[pos];
    assign rd_key   = keys_reg[idx_reg[IW-1:0]];
    assign sum      = {1'b0, total_reg} + 33'(req_reg.entry_size);

    // move rewrites the youngest slot after the shift, append fills the next free one
    assign wr    = cmd.move || cmd.append;
    assign wpos  = cmd.move ? IW'(count_reg - CW'(1)) : count_reg[IW-1:0];
    assign wkey  = req_reg.key;
    assign wsize = cmd.move ? pos_size : req_reg.entry_size;

    always_comb
    begin
        keys_next  = keys_reg;
        sizes_next = sizes_reg;
        for (int j = 0; j < MAX_ENTRIES - 1; j++)
        begin
            if ((cmd.drop || cmd.move) && (IW'(j) >= pos))
            begin
                keys_next[j]  = keys_reg[j + 1];
                sizes_next[j] = sizes_reg[j + 1];
            end
        end
        if (wr)
        begin
            keys_next[wpos]  = wkey;
            sizes_next[wpos] = wsize;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.drop)
        begin
            count_next = count_reg - CW'(1);
        end
        else if (cmd.append)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_comb
    begin
        total_next = total_reg;
        if (cmd.add_total)
        begin
            total_next = sum[32] ? '1 : sum[31:0];
        end
        else if (cmd.sub_total)
        begin
            total_next = (total_reg >= 32'(pos_size)) ? total_reg - 32'(pos_size) : '0;
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.load)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        keys_reg  <= keys_next;
        sizes_reg <= sizes_next;
        if (cmd.load)
        begin
            req_reg <= req;
        end
        if (cmd.emit)
        begin
            rsp_reg.kind        <= cmd.kind;
            rsp_reg.out_key     <= (cmd.kind == sblt_pkg::KIND_EVICT) ? keys_reg[0]
                                                                       : req_reg.key;
            rsp_reg.found       <= (cmd.kind == sblt_pkg::KIND_DONE) && found_reg;
            rsp_reg.total_bytes <= total_next;
            rsp_reg.last        <= (cmd.kind == sblt_pkg::KIND_DONE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            total_reg     <= '0;
            budget_reg    <= sblt_pkg::BUDGET_RESET;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
            total_reg <= total_next;
            if (cfg_wr_en)
            begin
                budget_reg <= cfg_wr_data;
            end
            if (cmd.load)
            begin
                found_reg <= 1'b0;
            end
            else if (cmd.set_found)
            begin
                found_reg <= 1'b1;
            end
            rsp_valid_reg <= cmd.emit || (rsp_valid_reg && rsp_stall);
        end
    end

    assign stat.mode     = req_reg.mode;
    assign stat.out_free = !rsp_valid_reg || !rsp_stall;
    assign stat.over     = total_reg > budget_reg;
    assign stat.empty    = (count_reg == '0);
    assign stat.full     = (count_reg >= CW'(MAX_ENTRIES));
    assign stat.idx_end  = (idx_reg >= count_reg);
    assign stat.match    = !stat.idx_end && (rd_key == req_reg.key);

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== sv/size_budget_lru_tracker.sv =====
// top level of the size budget lru tracker: controller, datapath and checks
//
// keeps up to MAX_ENTRIES keyed entries in recency order (oldest first) with
// their sizes and a saturating running total, held against the byte budget
// register (reset 1048576, written through cfg_wr_en / cfg_wr_data)
// a request word asks for add, hit or delete; each request gives zero or more
// evicted or removed words and always ends with one done word (last set)
// add: sums the size in, evicts oldest entries one word each while over budget
// and the list is not empty, evicts once more if still full by count, then
// appends; hit: moves the oldest matching key to most recent; delete: removes
// every matching key, oldest first
// rate: one request at a time; an add walks the decode, budget eviction, full
// check and append states, a hit or delete scans the list oldest first, and an
// output stall holds each step that emits a word; the scan walks one slot per
// cycle through the single compare port
// each eviction or removal closes the gap in the list in the same cycle
// the next request is taken as soon as the done word sits in the output
// register, even while that word still waits on rsp_stall
// held keys and sizes have no reset; only the slots below the entry count are read
module size_budget_lru_tracker
#(
    parameter int MAX_ENTRIES = 16
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  sblt_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output sblt_pkg::rsp_t  rsp,
    input  logic            cfg_wr_en,
    input  logic [31:0]     cfg_wr_data
);

    sblt_pkg::cmd_t  cmd;
    sblt_pkg::stat_t stat;
    logic            busy;

    // request channel is open only between requests
    assign req_stall = busy;

    sblt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .stat      (stat),
        .cmd       (cmd),
        .busy      (busy)
    );

    sblt_datapath
    #(
        .MAX_ENTRIES (MAX_ENTRIES)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .stat        (stat),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp)
    );

`ifndef SYNTHESIS
    // a word is only loaded when the output register can take it
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("result word loaded over a waiting word");

    // append never overruns the store
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.append |-> !stat.full)
        else $error("append into a full list");

    // an entry is only dropped from a non-empty list
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drop |-> !stat.empty)
        else $error("drop from an empty list");

    // an accepted request closes the request channel on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request channel left open after accept");
`endif

endmodule
